// ----- rtl/certificate_status_table_top_defines.svh -----
// Assertion macros for the certificate status table.
// Included by the top level; depends on nothing else.
`ifndef CERTIFICATE_STATUS_TABLE_TOP_DEFINES_SVH
`define CERTIFICATE_STATUS_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cst_pkg.sv -----
// Shared types, codes and constants of the certificate status table.
// Used by the controller, the datapath and the top level.
package cst_pkg;

   localparam int CAPACITY_DEFAULT    = 32;
   localparam int SERIAL_BITS_DEFAULT = 64;
   localparam int FIELD_BITS          = 64;
   localparam int STATUS_BITS         = 3;
   localparam int ERROR_BITS          = 3;
   localparam int COUNT_BITS          = 6;
   localparam int CMD_BITS            = 2;
   localparam int REQ_DATA_BITS       = 328;
   localparam int RSP_DATA_BITS       = 80;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD,
      CMD_SET,
      CMD_GET,
      CMD_VALIDATE
   } cmd_type;

   localparam logic [STATUS_BITS-1:0] ST_UNKNOWN   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_ACTIVE    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_SUSPENDED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_REVOKED   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_EXPIRED   = 3'd4;

   localparam logic [ERROR_BITS-1:0] ERR_NONE           = 3'd0;
   localparam logic [ERROR_BITS-1:0] ERR_INVALID_INPUT  = 3'd1;
   localparam logic [ERROR_BITS-1:0] ERR_FULL           = 3'd2;
   localparam logic [ERROR_BITS-1:0] ERR_NOT_FOUND      = 3'd3;
   localparam logic [ERROR_BITS-1:0] ERR_REVOKED        = 3'd4;
   localparam logic [ERROR_BITS-1:0] ERR_EXPIRED        = 3'd5;
   localparam logic [ERROR_BITS-1:0] ERR_NOT_AUTHORIZED = 3'd6;
   localparam logic [ERROR_BITS-1:0] ERR_INVALID_STATE  = 3'd7;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOK_RD,
      S_LOOK_CMP,
      S_DEC_RD,
      S_EXEC,
      S_SCAN,
      S_TGT,
      S_CAS_RD,
      S_CAS_CMP,
      S_FIN_RD,
      S_FIN_OUT,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_FPOS,
      RD_JPOS,
      RD_RPOS
   } rd_src_type;

   typedef struct packed {
      logic       load;
      logic       look_cmp;
      logic       exec;
      logic       scan_step;
      logic       tgt_load;
      logic       cas_cmp;
      logic       out_load;
      rd_src_type rd_src;
   } ctl_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic cascade;
      logic pend_any;
      logic pend_here;
   } dp_stat_type;

endpackage

// ----- rtl/cst_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies.
module cst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cst_ctrl.sv -----
// Controller state machine of the certificate status table.
// Depends on cst_pkg; drives the datapath through command and status structs.
module cst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  cst_pkg::dp_stat_type stat,
   output cst_pkg::ctl_cmd_type ctl
);

   cst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cst_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cst_pkg::S_IDLE: begin
            if (req_tvalid) state_in = cst_pkg::S_LOOK_RD;
         end
         cst_pkg::S_LOOK_RD:  state_in = cst_pkg::S_LOOK_CMP;
         cst_pkg::S_LOOK_CMP: begin
            if (stat.hit || stat.last) state_in = cst_pkg::S_DEC_RD;
            else state_in = cst_pkg::S_LOOK_RD;
         end
         cst_pkg::S_DEC_RD: state_in = cst_pkg::S_EXEC;
         cst_pkg::S_EXEC: begin
            if (stat.cascade) state_in = cst_pkg::S_SCAN;
            else state_in = cst_pkg::S_FIN_RD;
         end
         cst_pkg::S_SCAN: begin
            if (!stat.pend_any) state_in = cst_pkg::S_FIN_RD;
            else if (stat.pend_here) state_in = cst_pkg::S_TGT;
         end
         cst_pkg::S_TGT:    state_in = cst_pkg::S_CAS_RD;
         cst_pkg::S_CAS_RD: state_in = cst_pkg::S_CAS_CMP;
         cst_pkg::S_CAS_CMP: begin
            if (stat.last) state_in = cst_pkg::S_SCAN;
            else state_in = cst_pkg::S_CAS_RD;
         end
         cst_pkg::S_FIN_RD:  state_in = cst_pkg::S_FIN_OUT;
         cst_pkg::S_FIN_OUT: state_in = cst_pkg::S_RESP;
         cst_pkg::S_RESP: begin
            if (rsp_tready) state_in = cst_pkg::S_IDLE;
         end
         default: state_in = cst_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctl        = '0;
      ctl.rd_src = cst_pkg::RD_IDX;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         cst_pkg::S_IDLE: begin
            req_tready = 1'b1;
            ctl.load   = req_tvalid;
         end
         cst_pkg::S_LOOK_RD:  ctl.rd_src = cst_pkg::RD_IDX;
         cst_pkg::S_LOOK_CMP: ctl.look_cmp = 1'b1;
         cst_pkg::S_DEC_RD:   ctl.rd_src = cst_pkg::RD_FPOS;
         cst_pkg::S_EXEC:     ctl.exec = 1'b1;
         cst_pkg::S_SCAN: begin
            ctl.scan_step = 1'b1;
            ctl.rd_src    = cst_pkg::RD_JPOS;
         end
         cst_pkg::S_TGT:     ctl.tgt_load = 1'b1;
         cst_pkg::S_CAS_RD:  ctl.rd_src = cst_pkg::RD_IDX;
         cst_pkg::S_CAS_CMP: ctl.cas_cmp = 1'b1;
         cst_pkg::S_FIN_RD:  ctl.rd_src = cst_pkg::RD_RPOS;
         cst_pkg::S_FIN_OUT: ctl.out_load = 1'b1;
         cst_pkg::S_RESP:    rsp_tvalid = 1'b1;
         default: ctl = '0;
      endcase
   end

endmodule

// ----- rtl/cst_dp.sv -----
// Datapath of the certificate status table: record memories, flags and counters.
// Depends on cst_pkg and cst_ram; steered by cst_ctrl.
module cst_dp #(
   parameter int CAPACITY    = cst_pkg::CAPACITY_DEFAULT,
   parameter int SERIAL_BITS = cst_pkg::SERIAL_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cst_pkg::ctl_cmd_type                  ctl,
   output cst_pkg::dp_stat_type                  stat,
   input  logic [cst_pkg::CMD_BITS-1:0]          in_cmd,
   input  logic [cst_pkg::FIELD_BITS-1:0]        in_serial,
   input  logic [cst_pkg::FIELD_BITS-1:0]        in_issuer,
   input  logic [cst_pkg::FIELD_BITS-1:0]        in_valid_from,
   input  logic [cst_pkg::FIELD_BITS-1:0]        in_valid_to,
   input  logic [cst_pkg::STATUS_BITS-1:0]       in_new_status,
   input  logic [cst_pkg::FIELD_BITS-1:0]        in_now,
   output logic [cst_pkg::ERROR_BITS-1:0]        out_error,
   output logic [cst_pkg::STATUS_BITS-1:0]       out_status,
   output logic [cst_pkg::FIELD_BITS-1:0]        out_status_time,
   output logic [cst_pkg::COUNT_BITS-1:0]        out_entry_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int FW    = cst_pkg::FIELD_BITS;
   localparam int SW    = cst_pkg::STATUS_BITS;

   cst_pkg::cmd_type                 cmd_ff;
   logic [SERIAL_BITS-1:0]           key_ff, iss_ff, target_ff;
   logic [FW-1:0]                    from_ff, to_ff, now_ff;
   logic [SW-1:0]                    ns_ff;
   logic [IDX_W-1:0]                 idx_ff, jpos_ff, fpos_ff, free_ff, rpos_ff;
   logic                             found_ff, free_ok_ff, rfound_ff;
   logic [cst_pkg::ERROR_BITS-1:0]   err_ff;
   logic [CAPACITY-1:0]              occ_ff, pend_ff;
   logic [CNT_W-1:0]                 total_ff;
   logic [cst_pkg::ERROR_BITS-1:0]   out_error_ff;
   logic [SW-1:0]                    out_status_ff;
   logic [FW-1:0]                    out_time_ff;

   logic [IDX_W-1:0]       rd_addr, wr_addr;
   logic [SERIAL_BITS-1:0] ser_rd, iss_rd;
   logic [FW-1:0]          from_rd, to_rd, tm_rd;
   logic [SW-1:0]          st_rd;
   logic                   we_all, we_st;
   logic [SW-1:0]          st_wdata;

   logic                           good, elig, last;
   logic [cst_pkg::ERROR_BITS-1:0] ex_err;
   logic                           ex_wall, ex_wst, ex_new, ex_cas, ex_rfound;
   logic [IDX_W-1:0]               ex_wpos, ex_rpos;
   logic [SW-1:0]                  ex_wstat;

   always_comb begin
      unique case (ctl.rd_src)
         cst_pkg::RD_IDX:  rd_addr = idx_ff;
         cst_pkg::RD_FPOS: rd_addr = fpos_ff;
         cst_pkg::RD_JPOS: rd_addr = jpos_ff;
         cst_pkg::RD_RPOS: rd_addr = rpos_ff;
         default:          rd_addr = idx_ff;
      endcase
   end

   assign good = (ns_ff >= cst_pkg::ST_ACTIVE) && (ns_ff <= cst_pkg::ST_EXPIRED);
   assign last = (idx_ff == IDX_W'(CAPACITY - 1));
   assign elig = occ_ff[idx_ff] && (st_rd != cst_pkg::ST_REVOKED) && (ser_rd != iss_rd)
                 && (iss_rd == target_ff);

   always_comb begin
      ex_err    = cst_pkg::ERR_NONE;
      ex_wall   = 1'b0;
      ex_wst    = 1'b0;
      ex_new    = 1'b0;
      ex_cas    = 1'b0;
      ex_wpos   = fpos_ff;
      ex_wstat  = ns_ff;
      ex_rfound = found_ff;
      ex_rpos   = fpos_ff;
      case (cmd_ff)
         cst_pkg::CMD_ADD: begin
            if ((key_ff == '0) || !good) begin
               ex_err = cst_pkg::ERR_INVALID_INPUT;
            end else if (found_ff) begin
               ex_wall = 1'b1;
               ex_cas  = (ns_ff == cst_pkg::ST_REVOKED);
            end else if (free_ok_ff) begin
               ex_wall   = 1'b1;
               ex_new    = 1'b1;
               ex_wpos   = free_ff;
               ex_rfound = 1'b1;
               ex_rpos   = free_ff;
               ex_cas    = (ns_ff == cst_pkg::ST_REVOKED);
            end else begin
               ex_err = cst_pkg::ERR_FULL;
            end
         end
         cst_pkg::CMD_SET: begin
            if (!good) begin
               ex_err = cst_pkg::ERR_INVALID_INPUT;
            end else if (!found_ff) begin
               ex_err = cst_pkg::ERR_NOT_FOUND;
            end else if ((st_rd == cst_pkg::ST_REVOKED) && (ns_ff != cst_pkg::ST_REVOKED)) begin
               ex_err = cst_pkg::ERR_REVOKED;
            end else begin
               ex_wst = 1'b1;
               ex_cas = (ns_ff == cst_pkg::ST_REVOKED);
            end
         end
         cst_pkg::CMD_GET: begin
            if (!found_ff) ex_err = cst_pkg::ERR_NOT_FOUND;
         end
         default: begin
            if (!found_ff) begin
               ex_err = cst_pkg::ERR_NOT_FOUND;
            end else begin
               unique case (st_rd)
                  cst_pkg::ST_ACTIVE: begin
                     if (!((now_ff >= from_rd) && (now_ff <= to_rd))) begin
                        ex_wst   = 1'b1;
                        ex_wstat = cst_pkg::ST_EXPIRED;
                        ex_err   = cst_pkg::ERR_EXPIRED;
                     end
                  end
                  cst_pkg::ST_SUSPENDED: ex_err = cst_pkg::ERR_NOT_AUTHORIZED;
                  cst_pkg::ST_REVOKED:   ex_err = cst_pkg::ERR_REVOKED;
                  cst_pkg::ST_EXPIRED:   ex_err = cst_pkg::ERR_EXPIRED;
                  default:               ex_err = cst_pkg::ERR_INVALID_STATE;
               endcase
            end
         end
      endcase
   end

   assign wr_addr  = ctl.cas_cmp ? idx_ff : ex_wpos;
   assign we_all   = ctl.exec && ex_wall;
   assign we_st    = (ctl.exec && (ex_wall || ex_wst)) || (ctl.cas_cmp && elig);
   assign st_wdata = ctl.cas_cmp ? cst_pkg::ST_REVOKED : ex_wstat;

   cst_ram #(.WIDTH(SERIAL_BITS), .DEPTH(CAPACITY)) u_serial_ram (
      .clock(clock), .wr_en(we_all), .wr_addr(wr_addr), .wr_data(key_ff),
      .rd_addr(rd_addr), .rd_data(ser_rd));
   cst_ram #(.WIDTH(SERIAL_BITS), .DEPTH(CAPACITY)) u_issuer_ram (
      .clock(clock), .wr_en(we_all), .wr_addr(wr_addr), .wr_data(iss_ff),
      .rd_addr(rd_addr), .rd_data(iss_rd));
   cst_ram #(.WIDTH(FW), .DEPTH(CAPACITY)) u_from_ram (
      .clock(clock), .wr_en(we_all), .wr_addr(wr_addr), .wr_data(from_ff),
      .rd_addr(rd_addr), .rd_data(from_rd));
   cst_ram #(.WIDTH(FW), .DEPTH(CAPACITY)) u_to_ram (
      .clock(clock), .wr_en(we_all), .wr_addr(wr_addr), .wr_data(to_ff),
      .rd_addr(rd_addr), .rd_data(to_rd));
   cst_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_status_ram (
      .clock(clock), .wr_en(we_st), .wr_addr(wr_addr), .wr_data(st_wdata),
      .rd_addr(rd_addr), .rd_data(st_rd));
   cst_ram #(.WIDTH(FW), .DEPTH(CAPACITY)) u_time_ram (
      .clock(clock), .wr_en(we_st), .wr_addr(wr_addr), .wr_data(now_ff),
      .rd_addr(rd_addr), .rd_data(tm_rd));

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= cst_pkg::cmd_type'(in_cmd);
         key_ff  <= in_serial[SERIAL_BITS-1:0];
         iss_ff  <= in_issuer[SERIAL_BITS-1:0];
         from_ff <= in_valid_from;
         to_ff   <= in_valid_to;
         ns_ff   <= in_new_status;
         now_ff  <= in_now;
      end
      if (ctl.look_cmp) begin
         if (occ_ff[idx_ff] && (ser_rd == key_ff)) fpos_ff <= idx_ff;
         if (!occ_ff[idx_ff] && !free_ok_ff) free_ff <= idx_ff;
      end
      if (ctl.exec) begin
         err_ff  <= ex_err;
         rpos_ff <= ex_rpos;
      end
      if (ctl.tgt_load) target_ff <= ser_rd;
      if (ctl.out_load) begin
         out_error_ff  <= err_ff;
         out_status_ff <= rfound_ff ? st_rd : cst_pkg::ST_UNKNOWN;
         out_time_ff   <= rfound_ff ? tm_rd : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         jpos_ff    <= '0;
         found_ff   <= 1'b0;
         free_ok_ff <= 1'b0;
         rfound_ff  <= 1'b0;
         occ_ff     <= '0;
         pend_ff    <= '0;
         total_ff   <= '0;
      end else begin
         if (ctl.load) begin
            idx_ff     <= '0;
            found_ff   <= 1'b0;
            free_ok_ff <= 1'b0;
         end
         if (ctl.look_cmp) begin
            if (occ_ff[idx_ff] && (ser_rd == key_ff)) found_ff <= 1'b1;
            if (!occ_ff[idx_ff]) free_ok_ff <= 1'b1;
            if (!last) idx_ff <= IDX_W'(idx_ff + 1'b1);
         end
         if (ctl.exec) begin
            rfound_ff <= ex_rfound;
            if (ex_new) begin
               occ_ff[ex_wpos] <= 1'b1;
               total_ff        <= CNT_W'(total_ff + 1'b1);
            end
            if (ex_cas) begin
               pend_ff <= CAPACITY'(1'b1) << ex_wpos;
               jpos_ff <= '0;
            end
         end
         if (ctl.scan_step && (pend_ff != '0)) begin
            if (pend_ff[jpos_ff]) begin
               pend_ff[jpos_ff] <= 1'b0;
            end else if (jpos_ff == IDX_W'(CAPACITY - 1)) begin
               jpos_ff <= '0;
            end else begin
               jpos_ff <= IDX_W'(jpos_ff + 1'b1);
            end
         end
         if (ctl.tgt_load) idx_ff <= '0;
         if (ctl.cas_cmp) begin
            if (elig) pend_ff[idx_ff] <= 1'b1;
            if (!last) idx_ff <= IDX_W'(idx_ff + 1'b1);
         end
      end
   end

   assign stat.hit       = occ_ff[idx_ff] && (ser_rd == key_ff);
   assign stat.last      = last;
   assign stat.cascade   = ex_cas;
   assign stat.pend_any  = (pend_ff != '0);
   assign stat.pend_here = pend_ff[jpos_ff];

   assign out_error       = out_error_ff;
   assign out_status      = out_status_ff;
   assign out_status_time = out_time_ff;
   assign out_entry_count = cst_pkg::COUNT_BITS'(total_ff);

endmodule

// ----- rtl/certificate_status_table_top.sv -----
// Top level of the certificate status table: controller plus datapath.
// Depends on cst_pkg, cst_ctrl, cst_dp and the assertion macro header.
//
//   Channel   Direction  Contents
//   req_*     in         one command with its certificate fields
//   rsp_*     out        error, status, status time and entry count
//
// One request at a time. A request reads and compares the entries in turn until
// a hit or the last entry, then decodes and executes, reads back and registers the
// response, presents it until it is taken and returns to idle; a revocation adds,
// per revoked entry, a read and compare of every entry, and a pointer scan for
// pending entries that ends when none is left.
// The record memories share one read port, so these steps run one after another.
// Reset clears occupancy and the count; the memories need no clearing.
// A stalled response holds the block; req_tready is low until it is taken.
`include "certificate_status_table_top_defines.svh"

module certificate_status_table_top #(
   parameter int CAPACITY    = cst_pkg::CAPACITY_DEFAULT,
   parameter int SERIAL_BITS = cst_pkg::SERIAL_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // serial[63:0], issuer[127:64], valid_from[191:128], valid_to[255:192],
   // new_status[258:256], now[322:259], zero pad[327:323]
   input  logic [cst_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // cmd[1:0]
   input  logic [cst_pkg::CMD_BITS-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // error[2:0], status[5:3], status_time[69:6], entry_count[75:70], zero pad[79:76]
   output logic [cst_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   cst_pkg::ctl_cmd_type ctl;
   cst_pkg::dp_stat_type stat;

   logic [cst_pkg::ERROR_BITS-1:0]  rsp_error;
   logic [cst_pkg::STATUS_BITS-1:0] rsp_status;
   logic [cst_pkg::FIELD_BITS-1:0]  rsp_status_time;
   logic [cst_pkg::COUNT_BITS-1:0]  rsp_entry_count;

   cst_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .ctl(ctl));

   cst_dp #(.CAPACITY(CAPACITY), .SERIAL_BITS(SERIAL_BITS)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .stat(stat),
      .in_cmd(req_tuser),
      .in_serial(req_tdata[63:0]),
      .in_issuer(req_tdata[127:64]),
      .in_valid_from(req_tdata[191:128]),
      .in_valid_to(req_tdata[255:192]),
      .in_new_status(req_tdata[258:256]),
      .in_now(req_tdata[322:259]),
      .out_error(rsp_error),
      .out_status(rsp_status),
      .out_status_time(rsp_status_time),
      .out_entry_count(rsp_entry_count));

   assign rsp_tdata = {4'd0, rsp_entry_count, rsp_status_time, rsp_status, rsp_error};

   `CST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while busy")
   `CST_ASSERT_NOW(a_one_side_open, clock, reset, rsp_tvalid, !req_tready, "ready for request while response pending")
   `CST_ASSERT_NOW(a_absent_reads_zero, clock, reset, rsp_tvalid && (rsp_tdata[2:0] == cst_pkg::ERR_NOT_FOUND), rsp_tdata[69:3] == '0, "absent entry reported nonzero status")

endmodule

// ----- verif/tb_certificate_status_table_top.sv -----
// Self-checking testbench of the certificate status table top level.
// Needs cst_pkg and certificate_status_table_top; a directed table is followed by
// random requests, each response checked against a predictor of the table.
module tb_certificate_status_table_top;

   localparam int SLOTS = 32;
   localparam int RANDOM_REQUESTS = 1430;
   localparam int QUIET_FROM = 1250;
   localparam longint CYCLE_LIMIT = 25000000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int SB = cst_pkg::STATUS_BITS;
   localparam int EB = cst_pkg::ERROR_BITS;
   localparam int CB = cst_pkg::COUNT_BITS;

   typedef struct {
      cst_pkg::cmd_type cmd;
      logic [63:0]      serial;
      logic [63:0]      issuer;
      logic [63:0]      valid_from;
      logic [63:0]      valid_to;
      logic [SB-1:0]    new_status;
      logic [63:0]      now;
   } request_type;

   typedef struct packed {
      logic [EB-1:0] error;
      logic [SB-1:0] status;
      logic [63:0]   status_time;
      logic [CB-1:0] entry_count;
   } response_type;

   typedef struct {
      request_type  req;
      bit           typed;
      response_type rsp;
   } row_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_tvalid;
   logic                                  req_tready;
   logic [cst_pkg::REQ_DATA_BITS-1:0]     req_tdata;
   logic [cst_pkg::CMD_BITS-1:0]          req_tuser;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready;
   logic [cst_pkg::RSP_DATA_BITS-1:0]     rsp_tdata;

   bit            slot_used [SLOTS];
   logic [63:0]   slot_serial [SLOTS];
   logic [63:0]   slot_issuer [SLOTS];
   logic [63:0]   slot_from [SLOTS];
   logic [63:0]   slot_to [SLOTS];
   logic [SB-1:0] slot_status [SLOTS];
   logic [63:0]   slot_time [SLOTS];
   bit            revoke_mark [SLOTS];
   int            used_total;

   response_type pending_responses[$];
   request_type  current_request;
   bit           current_typed;
   response_type current_typed_rsp;
   row_type      directed_rows[$];
   int           mismatch_count;
   int           checked_count;
   int           cascade_count;
   longint       cycle_count;
   bit           quiet;
   bit           stimulus_done;

   certificate_status_table_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int find_serial(logic [63:0] key);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i] && slot_serial[i] == key) return i;
      end
      return SLOTS;
   endfunction

   function automatic int find_free();
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_used[i]) return i;
      end
      return SLOTS;
   endfunction

   function automatic void revoke_descendants(int root, logic [63:0] now);
      bit changed;
      changed = 1'b1;
      foreach (revoke_mark[i]) revoke_mark[i] = 1'b0;
      revoke_mark[root] = 1'b1;
      cascade_count++;
      while (changed) begin
         changed = 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i] || slot_status[i] == cst_pkg::ST_REVOKED) continue;
            if (slot_serial[i] == slot_issuer[i]) continue;
            for (int j = 0; j < SLOTS; j++) begin
               if (revoke_mark[j] && slot_used[j] && slot_serial[j] == slot_issuer[i]) begin
                  slot_status[i] = cst_pkg::ST_REVOKED;
                  slot_time[i] = now;
                  revoke_mark[i] = 1'b1;
                  changed = 1'b1;
                  break;
               end
            end
         end
      end
   endfunction

   function automatic response_type apply_request(request_type r);
      response_type res;
      int pos;
      bit good;
      good = r.new_status >= cst_pkg::ST_ACTIVE && r.new_status <= cst_pkg::ST_EXPIRED;
      res.error = cst_pkg::ERR_NONE;
      pos = find_serial(r.serial);
      case (r.cmd)
         cst_pkg::CMD_ADD: begin
            if (r.serial == 0 || !good) begin
               res.error = cst_pkg::ERR_INVALID_INPUT;
            end else begin
               if (pos == SLOTS) begin
                  pos = find_free();
                  if (pos < SLOTS) begin
                     slot_used[pos] = 1'b1;
                     used_total++;
                  end
               end
               if (pos < SLOTS) begin
                  slot_serial[pos] = r.serial;
                  slot_issuer[pos] = r.issuer;
                  slot_from[pos] = r.valid_from;
                  slot_to[pos] = r.valid_to;
                  slot_status[pos] = r.new_status;
                  slot_time[pos] = r.now;
                  if (r.new_status == cst_pkg::ST_REVOKED) revoke_descendants(pos, r.now);
               end else begin
                  res.error = cst_pkg::ERR_FULL;
               end
            end
         end
         cst_pkg::CMD_SET: begin
            if (!good) begin
               res.error = cst_pkg::ERR_INVALID_INPUT;
            end else if (pos == SLOTS) begin
               res.error = cst_pkg::ERR_NOT_FOUND;
            end else if (slot_status[pos] == cst_pkg::ST_REVOKED &&
                         r.new_status != cst_pkg::ST_REVOKED) begin
               res.error = cst_pkg::ERR_REVOKED;
            end else begin
               slot_status[pos] = r.new_status;
               slot_time[pos] = r.now;
               if (r.new_status == cst_pkg::ST_REVOKED) revoke_descendants(pos, r.now);
            end
         end
         cst_pkg::CMD_GET: begin
            if (pos == SLOTS) res.error = cst_pkg::ERR_NOT_FOUND;
         end
         default: begin
            if (pos == SLOTS) begin
               res.error = cst_pkg::ERR_NOT_FOUND;
            end else if (slot_status[pos] == cst_pkg::ST_ACTIVE) begin
               if (!(r.now >= slot_from[pos] && r.now <= slot_to[pos])) begin
                  slot_status[pos] = cst_pkg::ST_EXPIRED;
                  slot_time[pos] = r.now;
                  res.error = cst_pkg::ERR_EXPIRED;
               end
            end else if (slot_status[pos] == cst_pkg::ST_SUSPENDED) begin
               res.error = cst_pkg::ERR_NOT_AUTHORIZED;
            end else if (slot_status[pos] == cst_pkg::ST_REVOKED) begin
               res.error = cst_pkg::ERR_REVOKED;
            end else if (slot_status[pos] == cst_pkg::ST_EXPIRED) begin
               res.error = cst_pkg::ERR_EXPIRED;
            end else begin
               res.error = cst_pkg::ERR_INVALID_STATE;
            end
         end
      endcase
      pos = find_serial(r.serial);
      res.status = (pos < SLOTS) ? slot_status[pos] : cst_pkg::ST_UNKNOWN;
      res.status_time = (pos < SLOTS) ? slot_time[pos] : 64'd0;
      res.entry_count = used_total[CB-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("Response %0d: %s is %0h, expected %0h", checked_count, field, got, want);
   endtask

   function automatic void add_row(cst_pkg::cmd_type cmd, logic [63:0] serial,
                                   logic [63:0] issuer, logic [63:0] from, logic [63:0] to,
                                   logic [SB-1:0] st, logic [63:0] now,
                                   bit typed = 1'b0,
                                   logic [EB-1:0] err = cst_pkg::ERR_NONE,
                                   logic [SB-1:0] rst = cst_pkg::ST_UNKNOWN,
                                   logic [63:0] rtime = 64'd0, int count = 0);
      row_type row;
      row.req = '{cmd, serial, issuer, from, to, st, now};
      row.typed = typed;
      row.rsp = '{err, rst, rtime, count[CB-1:0]};
      directed_rows.push_back(row);
   endfunction

   function automatic logic [63:0] pick_serial();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return 64'($urandom_range(1, 40));
      if (roll < 85) return 64'd0;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_time();
      if ($urandom_range(0, 9) < 7) return 64'($urandom_range(0, 250));
      return {$urandom, $urandom};
   endfunction

   function automatic request_type random_request();
      request_type r;
      int roll;
      roll = $urandom_range(0, 99);
      r.cmd = roll < 35 ? cst_pkg::CMD_ADD : roll < 60 ? cst_pkg::CMD_SET
              : roll < 75 ? cst_pkg::CMD_GET : cst_pkg::CMD_VALIDATE;
      r.serial = pick_serial();
      roll = $urandom_range(0, 99);
      r.issuer = roll < 70 ? 64'($urandom_range(1, 40)) : roll < 80 ? r.serial
                 : {$urandom, $urandom};
      if ($urandom_range(0, 9) < 7) begin
         r.valid_from = 64'($urandom_range(0, 120));
         r.valid_to = r.valid_from + 64'($urandom_range(0, 130));
      end else begin
         r.valid_from = {$urandom, $urandom};
         r.valid_to = {$urandom, $urandom};
      end
      r.new_status = ($urandom_range(0, 99) < 85) ? SB'($urandom_range(1, 4))
                     : SB'($urandom_range(0, 7));
      r.now = pick_time();
      return r;
   endfunction

   task automatic send_request(request_type r, bit typed, response_type want, bit idle_ok);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      current_request = r;
      current_typed = typed;
      current_typed_rsp = want;
      req_tuser = r.cmd;
      req_tdata = {5'd0, r.now, r.new_status, r.valid_to, r.valid_from, r.issuer, r.serial};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Request side: reset, directed table, then random requests.
   initial begin
      response_type none;
      none = '{cst_pkg::ERR_NONE, cst_pkg::ST_UNKNOWN, 64'd0, '0};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = cst_pkg::CMD_GET;
      quiet = 1'b0;
      stimulus_done = 1'b0;
      add_row(cst_pkg::CMD_GET, 64'd5, 0, 0, 0, cst_pkg::ST_ACTIVE, 0, 1,
              cst_pkg::ERR_NOT_FOUND);
      add_row(cst_pkg::CMD_VALIDATE, 64'd5, 0, 0, 0, cst_pkg::ST_ACTIVE, 7, 1,
              cst_pkg::ERR_NOT_FOUND);
      add_row(cst_pkg::CMD_SET, 64'd5, 0, 0, 0, cst_pkg::ST_ACTIVE, 7, 1,
              cst_pkg::ERR_NOT_FOUND);
      add_row(cst_pkg::CMD_ADD, 64'd0, 1, 0, 9, cst_pkg::ST_ACTIVE, 7, 1,
              cst_pkg::ERR_INVALID_INPUT);
      add_row(cst_pkg::CMD_ADD, 64'd5, 1, 0, 9, cst_pkg::ST_UNKNOWN, 7, 1,
              cst_pkg::ERR_INVALID_INPUT);
      add_row(cst_pkg::CMD_ADD, 64'd5, 1, 0, 9, 3'd7, 7, 1, cst_pkg::ERR_INVALID_INPUT);
      add_row(cst_pkg::CMD_SET, 64'd5, 1, 0, 9, 3'd5, 7, 1, cst_pkg::ERR_INVALID_INPUT);
      add_row(cst_pkg::CMD_ADD, ALL_ONES, 0, 0, ALL_ONES, cst_pkg::ST_ACTIVE, ALL_ONES, 1,
              cst_pkg::ERR_NONE, cst_pkg::ST_ACTIVE, ALL_ONES, 1);
      add_row(cst_pkg::CMD_ADD, 64'd5, ALL_ONES, 10, 20, cst_pkg::ST_ACTIVE, 1, 1,
              cst_pkg::ERR_NONE, cst_pkg::ST_ACTIVE, 1, 2);
      add_row(cst_pkg::CMD_ADD, 64'd6, 64'd5, 0, 50, cst_pkg::ST_ACTIVE, 2);
      add_row(cst_pkg::CMD_ADD, 64'd7, 64'd6, 0, 50, cst_pkg::ST_ACTIVE, 3);
      add_row(cst_pkg::CMD_ADD, 64'd8, 64'd8, 0, 50, cst_pkg::ST_ACTIVE, 4);
      add_row(cst_pkg::CMD_ADD, 64'd9, 64'd7, 0, 50, cst_pkg::ST_SUSPENDED, 4);
      add_row(cst_pkg::CMD_VALIDATE, 64'd5, 0, 0, 0, cst_pkg::ST_ACTIVE, 15);
      add_row(cst_pkg::CMD_VALIDATE, 64'd5, 0, 0, 0, cst_pkg::ST_ACTIVE, 25);
      add_row(cst_pkg::CMD_VALIDATE, 64'd5, 0, 0, 0, cst_pkg::ST_ACTIVE, 26);
      add_row(cst_pkg::CMD_SET, 64'd6, 0, 0, 0, cst_pkg::ST_SUSPENDED, 30);
      add_row(cst_pkg::CMD_VALIDATE, 64'd6, 0, 0, 0, cst_pkg::ST_ACTIVE, 31);
      add_row(cst_pkg::CMD_SET, ALL_ONES, 0, 0, 0, cst_pkg::ST_REVOKED, 100);
      add_row(cst_pkg::CMD_VALIDATE, 64'd9, 0, 0, 0, cst_pkg::ST_ACTIVE, 101);
      add_row(cst_pkg::CMD_SET, 64'd7, 0, 0, 0, cst_pkg::ST_ACTIVE, 102);
      add_row(cst_pkg::CMD_SET, 64'd7, 0, 0, 0, cst_pkg::ST_REVOKED, 103);
      add_row(cst_pkg::CMD_ADD, 64'd6, 64'd5, 0, 0, cst_pkg::ST_REVOKED, 104);
      add_row(cst_pkg::CMD_GET, 64'd8, 0, 0, 0, cst_pkg::ST_ACTIVE, 105);
      add_row(cst_pkg::CMD_ADD, 64'd7, 64'd6, 0, 0, cst_pkg::ST_EXPIRED, 106);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp, 1'b1);
      end
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == QUIET_FROM) quiet = 1'b1;
         send_request(random_request(), 1'b0, none, !quiet);
      end
      req_tvalid = 1'b0;
      stimulus_done = 1'b1;
   end

   // Response side back-pressure in bursts.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      response_type want;
      response_type got;
      if (!reset && req_tvalid && req_tready) begin
         want = apply_request(current_request);
         if (current_typed && want != current_typed_rsp) begin
            report_mismatch("table entry", 64'(current_typed_rsp.error), 64'(want.error));
         end
         pending_responses.push_back(want);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_count++;
         got.error = rsp_tdata[2:0];
         got.status = rsp_tdata[5:3];
         got.status_time = rsp_tdata[69:6];
         got.entry_count = rsp_tdata[75:70];
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", 64'(got.error), 64'd0);
         end else begin
            want = pending_responses.pop_front();
            if (got.error != want.error)
               report_mismatch("error", 64'(got.error), 64'(want.error));
            if (got.status != want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.status_time != want.status_time)
               report_mismatch("status_time", got.status_time, want.status_time);
            if (got.entry_count != want.entry_count)
               report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      mismatch_count = 0;
      checked_count = 0;
      cascade_count = 0;
      used_total = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      wait (stimulus_done);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (pending_responses.size() != 0) mismatch_count++;
      $display("Checked %0d responses, %0d revocation cascades, table holding %0d entries.",
               checked_count, cascade_count, used_total);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
